// ----- rtl/mlp_fwd_pkg.sv -----
`timescale 1ns / 1ps
package mlp_fwd_pkg;

  localparam int DEF_MAX_INPUTS  = 16;
  localparam int DEF_MAX_HIDDEN  = 8;
  localparam int DEF_MAX_OUTPUTS = 4;
  localparam int DEF_SIG_DEPTH   = 256;

  localparam int VAL_W = 16;
  localparam int ACC_W = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;
  localparam int FRAC_BITS  = 12;

  localparam logic signed [VAL_W-1:0] FX_ONE  = 16'sd4096;
  localparam logic signed [VAL_W-1:0] SAT_MAX = 16'sh7fff;
  localparam logic signed [VAL_W-1:0] SAT_MIN = 16'sh8000;

  localparam logic [CFG_IDX_W-1:0] REG_INPUTS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIDDEN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUTS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACT     = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE, S_ISSUE, S_DRAIN1, S_DRAIN2, S_SAT, S_IDX, S_LUT, S_RES
  } state_t;

  typedef struct packed {
    logic issue;
    logic clr;
  } mac_ctl_t;

  // logistic value at the center of segment i, seg is the segment width
  function automatic logic [VAL_W-1:0] sig_entry(int i, real seg);
    real c;
    real v;
    c = -8.0 + seg * (real'(i) + 0.5);
    v = 2048.0 * (1.0 + $tanh(0.5 * c));
    return VAL_W'($rtoi(v + 0.5));
  endfunction

endpackage

// ----- rtl/mlp_forward_pass.sv -----
`timescale 1ns / 1ps
// Fixed-point forward pass of a small fully connected network.
// Input channel (in_valid/in_stall, kind/index/value/last): kind 0 writes one
// weight at index, kind 1 stores sample value for input node index; a kind 1
// beat with last set starts an evaluation. in_stall stays high during it.
// Output channel (out_valid/out_stall): one beat per output neuron in order,
// final_res marks the last one. A single output register holds a beat while
// the receiver stalls; the sequencer waits there before writing the next.
// Config port (cfg_we/cfg_index/cfg_data): the user writes it only while the
// block is idle; the block itself does not enforce this. Weights and stored
// sample values are used as written; reset only clears control state and
// restores the register defaults. An evaluation walks one weight per cycle
// through the shared multiply-accumulate, with sources circulating in a ring
// of cells; output stalls lengthen a full pass.
module mlp_forward_pass #(
  parameter int MAX_INPUTS          = mlp_fwd_pkg::DEF_MAX_INPUTS,
  parameter int MAX_HIDDEN          = mlp_fwd_pkg::DEF_MAX_HIDDEN,
  parameter int MAX_OUTPUTS         = mlp_fwd_pkg::DEF_MAX_OUTPUTS,
  parameter int SIGMOID_TABLE_DEPTH = mlp_fwd_pkg::DEF_SIG_DEPTH
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    kind,
  input  logic [7:0]                              index,
  input  logic signed [15:0]                      value,
  input  logic                                    last,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [1:0]                              output_number,
  output logic signed [15:0]                      output_value,
  output logic                                    final_res,
  input  logic                                    cfg_we,
  input  logic [mlp_fwd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mlp_fwd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import mlp_fwd_pkg::*;

  localparam int STORE = MAX_HIDDEN * (MAX_INPUTS + 1) + MAX_OUTPUTS * (MAX_HIDDEN + 1);
  localparam int AW    = $clog2(STORE);
  localparam int NMAX  = (MAX_HIDDEN > MAX_OUTPUTS) ? MAX_HIDDEN : MAX_OUTPUTS;
  localparam int NW    = $clog2(NMAX + 1);
  localparam int SMAX  = (MAX_INPUTS > MAX_HIDDEN) ? MAX_INPUTS : MAX_HIDDEN;
  localparam int SW    = $clog2(SMAX + 2);
  localparam int TW    = $clog2(SIGMOID_TABLE_DEPTH);
  localparam int DW    = $clog2(SIGMOID_TABLE_DEPTH + 1);
  localparam real SEG  = 16.0 / SIGMOID_TABLE_DEPTH;

  state_t state, state_next;
  mac_ctl_t mac_ctl;

  logic [4:0] inputs_in_use;
  logic [3:0] hidden_in_use;
  logic [2:0] outputs_in_use;
  logic       bias_enable;
  logic       activation_enable;

  logic          hid_phase;
  logic [NW-1:0] nc;
  logic [SW-1:0] sc;
  logic [AW-1:0] base;

  logic [SW-1:0] ni, nh, n, lst;
  logic [NW-1:0] no, nc_last;
  logic          in_acc, start, res_fire, out_blocked, src_live;
  logic          shift_s, shift_h, load_h;

  logic signed [VAL_W-1:0] weight_mem [STORE];
  logic signed [VAL_W-1:0] rdata;
  logic signed [VAL_W-1:0] src;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-FRAC_BITS-1:0] sh;
  logic signed [VAL_W-1:0] sh_q;
  logic signed [VAL_W-1:0] res;
  logic [VAL_W+DW-1:0]     idx_prod;
  logic [TW-1:0]           idx_q;
  logic [VAL_W-1:0]        lut_q;
  logic [VAL_W-1:0]        sig_rom [SIGMOID_TABLE_DEPTH];

  logic signed [VAL_W-1:0] s_q [MAX_INPUTS];
  logic signed [VAL_W-1:0] h_q [MAX_HIDDEN];

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign start    = in_acc && kind && last;

  // clamp counts to 1..MAX
  always_comb begin
    if (inputs_in_use == '0) ni = SW'(1);
    else if (int'(inputs_in_use) > MAX_INPUTS) ni = SW'(MAX_INPUTS);
    else ni = SW'(inputs_in_use);
    if (hidden_in_use == '0) nh = SW'(1);
    else if (int'(hidden_in_use) > MAX_HIDDEN) nh = SW'(MAX_HIDDEN);
    else nh = SW'(hidden_in_use);
    if (outputs_in_use == '0) no = NW'(1);
    else if (int'(outputs_in_use) > MAX_OUTPUTS) no = NW'(MAX_OUTPUTS);
    else no = NW'(outputs_in_use);
  end

  assign n        = hid_phase ? ni : nh;
  assign lst      = n - SW'(1) + SW'(bias_enable);
  assign nc_last  = hid_phase ? NW'(nh - SW'(1)) : (no - NW'(1));
  assign src_live = (sc < n);
  assign out_blocked = out_valid && out_stall;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      inputs_in_use     <= 5'd9;
      hidden_in_use     <= 4'd2;
      outputs_in_use    <= 3'd1;
      bias_enable       <= 1'b1;
      activation_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INPUTS:  inputs_in_use     <= cfg_data[4:0];
        REG_HIDDEN:  hidden_in_use     <= cfg_data[3:0];
        REG_OUTPUTS: outputs_in_use    <= cfg_data[2:0];
        REG_BIAS:    bias_enable       <= cfg_data[0];
        REG_ACT:     activation_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) state_next = S_ISSUE;
      S_ISSUE:  if (sc == lst) state_next = S_DRAIN1;
      S_DRAIN1: state_next = S_DRAIN2;
      S_DRAIN2: state_next = S_SAT;
      S_SAT:    state_next = S_IDX;
      S_IDX:    state_next = S_LUT;
      S_LUT:    state_next = S_RES;
      S_RES: begin
        if (hid_phase) state_next = S_ISSUE;
        else if (!out_blocked) state_next = (nc == nc_last) ? S_IDLE : S_ISSUE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    mac_ctl.issue = 1'b0;
    mac_ctl.clr   = 1'b0;
    res_fire      = 1'b0;
    unique case (state)
      S_IDLE:  mac_ctl.clr = 1'b1;
      S_ISSUE: mac_ctl.issue = 1'b1;
      S_SAT:   mac_ctl.clr = 1'b1;
      S_RES:   res_fire = hid_phase || !out_blocked;
      default: ;
    endcase
  end

  assign shift_s = mac_ctl.issue && hid_phase && src_live;
  assign shift_h = mac_ctl.issue && !hid_phase && src_live;
  assign load_h  = res_fire && hid_phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      hid_phase <= 1'b1;
      nc        <= '0;
      sc        <= '0;
      base      <= '0;
    end else begin
      state <= state_next;
      if (start) begin
        hid_phase <= 1'b1;
        nc        <= '0;
        sc        <= '0;
        base      <= '0;
      end else if (mac_ctl.issue && sc != lst) begin
        sc <= sc + SW'(1);
      end else if (res_fire) begin
        sc   <= '0;
        base <= base + AW'(n) + AW'(bias_enable);
        if (hid_phase && nc == nc_last) begin
          hid_phase <= 1'b0;
          nc        <= '0;
        end else begin
          nc <= nc + NW'(1);
        end
      end
    end
  end

  // weight store
  always_ff @(posedge clk) begin
    if (in_acc && !kind && int'(index) < STORE) begin
      weight_mem[AW'(index)] <= value;
    end
    if (mac_ctl.issue) begin
      rdata <= weight_mem[base + AW'(sc)];
    end
  end

  always_comb begin
    if (!src_live) src = FX_ONE;
    else if (hid_phase) src = s_q[0];
    else src = h_q[0];
  end

  mlp_fwd_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mac_ctl),
    .src    (src),
    .weight (rdata),
    .acc    (acc)
  );

  // sample ring: rotates over the first ni cells, unused cells hold
  for (genvar k = 0; k < MAX_INPUTS; k++) begin : g_sample
    logic signed [VAL_W-1:0] nxt;
    if (k == MAX_INPUTS - 1) begin : g_end
      assign nxt = s_q[0];
    end else begin : g_mid
      assign nxt = (SW'(k) == ni - SW'(1)) ? s_q[0] : s_q[k+1];
    end
    mlp_fwd_cell u_cell (
      .clk        (clk),
      .load       (in_acc && kind && int'(index) == k),
      .load_data  (value),
      .shift      (shift_s && SW'(k) < ni),
      .shift_data (nxt),
      .q          (s_q[k])
    );
  end

  // hidden ring: loaded by neuron number, rotates over the first nh cells
  for (genvar k = 0; k < MAX_HIDDEN; k++) begin : g_hidden
    logic signed [VAL_W-1:0] nxt;
    if (k == MAX_HIDDEN - 1) begin : g_end
      assign nxt = h_q[0];
    end else begin : g_mid
      assign nxt = (SW'(k) == nh - SW'(1)) ? h_q[0] : h_q[k+1];
    end
    mlp_fwd_cell u_cell (
      .clk        (clk),
      .load       (load_h && int'(nc) == k),
      .load_data  (res),
      .shift      (shift_h && SW'(k) < nh),
      .shift_data (nxt),
      .q          (h_q[k])
    );
  end

  // logistic table
  for (genvar g = 0; g < SIGMOID_TABLE_DEPTH; g++) begin : g_sig
    localparam logic [VAL_W-1:0] ENTRY = sig_entry(g, SEG);
    assign sig_rom[g] = ENTRY;
  end

  assign sh       = (ACC_W-FRAC_BITS)'(acc >>> FRAC_BITS);
  assign idx_prod = (VAL_W+DW)'({~sh_q[VAL_W-1], sh_q[VAL_W-2:0]}) *
                    (VAL_W+DW)'(SIGMOID_TABLE_DEPTH);
  assign res      = activation_enable ? lut_q : sh_q;

  always_ff @(posedge clk) begin
    if (state == S_SAT) begin
      if (sh > (ACC_W-FRAC_BITS)'(SAT_MAX)) sh_q <= SAT_MAX;
      else if (sh < (ACC_W-FRAC_BITS)'(SAT_MIN)) sh_q <= SAT_MIN;
      else sh_q <= VAL_W'(sh);
    end
    if (state == S_IDX) begin
      idx_q <= idx_prod[VAL_W +: TW];
    end
    if (state == S_LUT) begin
      lut_q <= sig_rom[idx_q];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_fire && !hid_phase) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire && !hid_phase) begin
      output_number <= nc[1:0];
      output_value  <= res;
      final_res     <= (nc == nc_last);
    end
  end

`ifndef SYNTHESIS
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ISSUE) |-> (sc <= lst))
    else $error("step counter ran past the bias step");
  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_ISSUE && sc == '0) |-> (acc == '0))
    else $error("accumulator not cleared at neuron start");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_RES && !hid_phase && !out_blocked) |=> out_valid)
    else $error("output beat not loaded");
`endif

endmodule

// ----- rtl/mlp_fwd_cell.sv -----
`timescale 1ns / 1ps
module mlp_fwd_cell (
  input  logic                             clk,
  input  logic                             load,
  input  logic signed [mlp_fwd_pkg::VAL_W-1:0] load_data,
  input  logic                             shift,
  input  logic signed [mlp_fwd_pkg::VAL_W-1:0] shift_data,
  output logic signed [mlp_fwd_pkg::VAL_W-1:0] q
);
  import mlp_fwd_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      q <= load_data;
    end else if (shift) begin
      q <= shift_data;
    end
  end

endmodule

// ----- rtl/mlp_fwd_mac.sv -----
`timescale 1ns / 1ps
module mlp_fwd_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mlp_fwd_pkg::mac_ctl_t                ctl,
  input  logic signed [mlp_fwd_pkg::VAL_W-1:0] src,
  input  logic signed [mlp_fwd_pkg::VAL_W-1:0] weight,
  output logic signed [mlp_fwd_pkg::ACC_W-1:0] acc
);
  import mlp_fwd_pkg::*;

  logic                      src_v;
  logic                      prod_v;
  logic signed [VAL_W-1:0]   src_d;
  logic signed [2*VAL_W-1:0] prod;

  // weight arrives in the cycle after issue, so hold the source beside it
  always_ff @(posedge clk) begin
    if (rst) begin
      src_v  <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      src_v  <= ctl.issue;
      prod_v <= src_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      src_d <= src;
    end
    prod <= src_d * weight;
    if (ctl.clr) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + ACC_W'(prod);
    end
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import mlp_fwd_pkg::*;

  localparam int N_IN = 16;
  localparam int N_HID = 8;
  localparam int N_OUT = 4;
  localparam int W_DEPTH = N_HID * (N_IN + 1) + N_OUT * (N_HID + 1);
  localparam int W_FILL = 64;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic              kind;
    logic [7:0]        index;
    logic signed [15:0] value;
    logic              last;
  } beat_t;

  typedef struct {
    logic [1:0]         num;
    logic signed [15:0] val;
    logic               fin;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = 1'b0;
  logic [7:0] index = '0;
  logic signed [15:0] value = '0;
  logic last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] output_number;
  logic signed [15:0] output_value;
  logic final_res;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mlp_forward_pass dut (.*);

  always #1 clk = ~clk;

  // predictor state
  logic signed [15:0] wmem [W_DEPTH];
  logic signed [15:0] smem [N_IN];
  logic [15:0] logistic_lut [256];
  int m_ni = 9, m_nh = 2, m_no = 1, m_bias = 1, m_act = 1;

  beat_t pending_beats[$];
  result_t expected_outputs[$];
  int errors = 0;
  int n_evals = 0;
  int n_results = 0;
  int n_sent = 0;
  bit tx_burst = 0, rx_burst = 0;
  bit hold_tog = 0, hold_seen = 0;
  int hold_cnt = 0;
  int tx_gap = 0;
  int rx_wait = 0;

  function automatic void add_beat(beat_t b);
    pending_beats = {pending_beats, b};
  endfunction

  initial begin
    real c;
    for (int i = 0; i < 256; i++) begin
      c = -8.0 + 16.0 * (real'(i) + 0.5) / 256.0;
      logistic_lut[i] = 16'($rtoi(4096.0 / (1.0 + $exp(-c)) + 0.5));
    end
  end

  function automatic int clamp_count(int v, int mx);
    if (v < 1) return 1;
    return (v > mx) ? mx : v;
  endfunction

  function automatic int weight_rd(int a);
    return (a < W_DEPTH) ? int'(wmem[a]) : 0;
  endfunction

  function automatic int neuron_out(int base, int src[N_IN], int n);
    longint acc;
    longint sh;
    acc = 0;
    for (int s = 0; s < n; s++) acc += longint'(src[s]) * weight_rd(base + s);
    if (m_bias != 0) acc += 64'sd4096 * weight_rd(base + n);
    sh = acc >>> FRAC_BITS;
    if (sh > 32767) sh = 32767;
    if (sh < -32768) sh = -32768;
    if (m_act != 0) return int'(logistic_lut[(sh + 32768) >> 8]);
    return int'(sh);
  endfunction

  task automatic predict_beat(beat_t b);
    int ni, nh, no, sz, ob;
    int src[N_IN];
    int hid[N_IN];
    result_t r;
    if (!b.kind) begin
      if (b.index < W_DEPTH) wmem[b.index] = b.value;
    end else begin
      if (b.index < N_IN) smem[b.index] = b.value;
      if (b.last) begin
        ni = clamp_count(m_ni, N_IN);
        nh = clamp_count(m_nh, N_HID);
        no = clamp_count(m_no, N_OUT);
        sz = ni + m_bias;
        for (int i = 0; i < N_IN; i++) begin
          src[i] = (i < ni) ? int'(smem[i]) : 0;
          hid[i] = 0;
        end
        for (int i = 0; i < nh; i++) hid[i] = neuron_out(i * sz, src, ni);
        ob = nh * sz;
        for (int i = 0; i < no; i++) begin
          r.num = 2'(i);
          r.val = 16'(neuron_out(ob + i * (nh + m_bias), hid, nh));
          r.fin = (i + 1 == no);
          expected_outputs = {expected_outputs, r};
        end
        n_evals++;
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    beat_t b;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_beat('{kind, index, value, last});
        n_sent++;
      end
      if (!(in_valid && in_stall)) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          b = pending_beats.pop_front();
          kind <= b.kind;
          index <= b.index;
          value <= b.value;
          last <= b.last;
          in_valid <= 1'b1;
          tx_gap <= tx_burst ? 0 : $urandom_range(0, 15);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_cnt <= HOLD_CYCLES;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    result_t e;
    int w;
    w = rx_wait;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_outputs.size() == 0) begin
          $display("%0t: unexpected beat num=%0d val=%0d fin=%0b", $time,
                   output_number, output_value, final_res);
          errors++;
        end else begin
          e = expected_outputs.pop_front();
          if (output_number !== e.num) begin
            $display("%0t: output_number exp %0d got %0d", $time, e.num, output_number);
            errors++;
          end
          if (output_value !== e.val) begin
            $display("%0t: output_value exp %0d got %0d", $time, e.val, output_value);
            errors++;
          end
          if (final_res !== e.fin) begin
            $display("%0t: final_res exp %0b got %0b", $time, e.fin, final_res);
            errors++;
          end
        end
        w = rx_burst ? 0 : $urandom_range(0, 15);
      end else if (w > 0) begin
        w--;
      end
      rx_wait <= w;
      out_stall <= (hold_cnt != 0) || (w != 0);
    end
  end

  function automatic logic signed [15:0] rand_val();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 8191)) - 4096);
  endfunction

  function automatic beat_t mk(logic k, int idx, logic signed [15:0] v, logic l);
    beat_t b;
    b.kind = k;
    b.index = 8'(idx);
    b.value = v;
    b.last = l;
    return b;
  endfunction

  task automatic wait_idle();
    while (pending_beats.size() != 0 || in_valid || expected_outputs.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(data);
    case (idx)
      REG_INPUTS:  m_ni = data & 5'h1f;
      REG_HIDDEN:  m_nh = data & 4'hf;
      REG_OUTPUTS: m_no = data & 3'h7;
      REG_BIAS:    m_bias = data & 1;
      REG_ACT:     m_act = data & 1;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(int ni, int nh, int no, int b, int a);
    wait_idle();
    write_reg(REG_INPUTS, ni);
    write_reg(REG_HIDDEN, nh);
    write_reg(REG_OUTPUTS, no);
    write_reg(REG_BIAS, b);
    write_reg(REG_ACT, a);
  endtask

  // one sample: up to three weight updates, then a value beat per node in use
  task automatic queue_sample(ref int cnt);
    int ni;
    ni = clamp_count(m_ni, N_IN);
    repeat ($urandom_range(0, 3)) begin
      add_beat(mk(0, $urandom_range(0, 255), rand_val(), 1'($urandom)));
      cnt++;
    end
    if ($urandom_range(0, 9) == 0) begin
      // broken sample: out-of-range node, maybe with last
      add_beat(mk(1, $urandom_range(16, 255), rand_val(), 1'($urandom)));
      cnt++;
      return;
    end
    for (int i = 0; i < ni; i++) begin
      add_beat(mk(1, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : i,
                  rand_val(), i == ni - 1));
      cnt++;
    end
  endtask

  task automatic random_phase(int n);
    int cnt;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 7) == 0) begin
        tx_burst = $urandom;
        rx_burst = $urandom;
      end
      queue_sample(cnt);
      while (pending_beats.size() > 8) @(posedge clk);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // fill the weights and samples that the configurations below read
    tx_burst = 1;
    for (int a = 0; a < W_FILL; a++) add_beat(mk(0, a, rand_val(), 0));
    for (int i = 0; i < N_IN; i++) add_beat(mk(1, i, rand_val(), 0));
    wait_idle();
    tx_burst = 0;

    // directed beats at the reset configuration
    add_beat(mk(0, 16'hff, 16'sh7fff, 0));
    add_beat(mk(0, W_DEPTH, 16'sh8000, 0));
    add_beat(mk(0, 3, 16'sh7fff, 1));
    add_beat(mk(1, 0, 16'sh7fff, 0));
    add_beat(mk(1, 1, 16'sh8000, 0));
    add_beat(mk(1, 2, 16'sh0000, 0));
    add_beat(mk(1, 3, -16'sd1, 1));
    add_beat(mk(1, 255, 16'sh5555, 1));
    add_beat(mk(1, 16, 16'shaaaa, 1));
    for (int i = 0; i < 9; i++) add_beat(mk(1, i, 16'sh7fff, i == 8));
    add_beat(mk(0, 0, 16'sh7fff, 0));
    add_beat(mk(1, 8, 16'sh8000, 1));

    // four outputs, with a long receiver hold-off while the sender keeps going
    set_config(4, 2, 4, 1, 1);
    rx_burst = 1;
    hold_tog = ~hold_tog;
    for (int i = 0; i < 4; i++) add_beat(mk(1, i, rand_val(), i == 3));
    for (int i = 0; i < 4; i++) add_beat(mk(1, i, rand_val(), i == 3));
    rx_burst = 0;
    random_phase(10);

    // over-range counts saturate, no bias, raw sums; unknown indexes ignored
    set_config(31, 1, 7, 0, 0);
    write_reg(3'd5, 31);
    write_reg(3'd6, 0);
    write_reg(3'd7, $urandom_range(0, 31));
    random_phase(16);
    set_config(1, 15, 1, 0, 1);
    random_phase(6);

    // zero counts clamp to one
    set_config(0, 0, 0, 1, 0);
    add_beat(mk(1, 0, 16'sh7fff, 1));
    add_beat(mk(1, 0, 16'sh8000, 1));
    add_beat(mk(1, 0, rand_val(), 1));

    set_config($urandom_range(1, 8), $urandom_range(1, 4), $urandom_range(1, 4),
               $urandom_range(0, 1), $urandom_range(0, 1));
    random_phase(15);
    set_config(1, 1, 1, 0, 1);
    random_phase(10);

    wait_idle();
    repeat (300) @(posedge clk);
    $display("Sent %0d beats, ran %0d evaluations, checked %0d output beats", n_sent,
             n_evals, n_results);
    $display("Covered count extremes and clamping, bias and activation on and off");
    if (errors == 0 && expected_outputs.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout waiting for output beats");
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mlp_fwd_pkg.sv
rtl/mlp_fwd_cell.sv
rtl/mlp_fwd_mac.sv
rtl/mlp_forward_pass.sv
dv/tb_top.sv
